### hw/rtl/clni_pkg.sv
// Shared constants, register codes and latency helper for the lattice neighbor index block.
package clni_pkg;

    localparam int IDX_W          = 23;
    localparam int MAX_EXTENT_DEF = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int XH_REG_W   = 6;
    localparam int EXT_REG_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_X_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_EXT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_EXT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_T_EXT  = 2'd3;

    localparam logic [XH_REG_W-1:0]  XH_RST  = 6'd4;
    localparam logic [EXT_REG_W-1:0] EXT_RST = 7'd8;

    // quotient widths of the three divider chains, bounded by the in-range coordinate sizes
    function automatic int clni_q1(input int max_ext);
        int cw;
        cw = $clog2(max_ext);
        return (3 * cw < IDX_W) ? 3 * cw : IDX_W;
    endfunction

    function automatic int clni_q2(input int max_ext);
        int cw;
        int q1;
        cw = $clog2(max_ext);
        q1 = clni_q1(max_ext);
        return (2 * cw < q1) ? 2 * cw : q1;
    endfunction

    function automatic int clni_q3(input int max_ext);
        int cw;
        int q2;
        cw = $clog2(max_ext);
        q2 = clni_q2(max_ext);
        return (cw < q2) ? cw : q2;
    endfunction

    // start-to-done stages: three dividers of (Q+1) stages plus two neighbor stages
    function automatic int clni_latency(input int max_ext);
        return clni_q1(max_ext) + clni_q2(max_ext) + clni_q3(max_ext) + 5;
    endfunction

endpackage

### hw/rtl/clni_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module clni_div #(
    parameter int DW = 23,
    parameter int VW = 7,
    parameter int QW = 18,
    parameter int PW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [VW-1:0] o_rem,
    output logic [PW-1:0] o_pay
);

    logic          r_vld [0:QW];
    logic [VW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_lq  [0:QW];
    logic [PW-1:0] r_pay [0:QW];

    // stage 0: high part of the dividend is the starting remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0] <= VW'(i_dividend >> QW);
        r_lq[0]  <= QW'(i_dividend);
        r_pay[0] <= i_pay;
    end

    genvar s;
    generate
        for (s = 1; s <= QW; s++) begin : g_step
            logic [VW:0]   n_trial;
            logic          n_ge;
            logic [VW-1:0] n_rem;
            logic [QW-1:0] n_lq;

            always_comb begin
                n_trial = {r_rem[s-1], r_lq[s-1][QW-1]};
                n_ge    = (n_trial >= {1'b0, i_divisor});
                n_rem   = n_ge ? VW'(n_trial - {1'b0, i_divisor}) : VW'(n_trial);
                n_lq    = QW'({r_lq[s-1], n_ge});
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= r_vld[s-1];
                end
                r_rem[s] <= n_rem;
                r_lq[s]  <= n_lq;
                r_pay[s] <= r_pay[s-1];
            end
        end
    endgenerate

    assign o_vld = r_vld[QW];
    assign o_quo = r_lq[QW];
    assign o_rem = r_rem[QW];
    assign o_pay = r_pay[QW];

endmodule

### hw/rtl/clni_cfg.sv
// Configuration registers, extent saturation and lattice stride products.
module clni_cfg #(
    parameter int MAX_EXTENT = clni_pkg::MAX_EXTENT_DEF,
    parameter int NXH_W      = 6,
    parameter int EW         = 7,
    parameter int SY_W       = 13,
    parameter int SZ_W       = 20,
    parameter int VOL_W      = 27
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [clni_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [clni_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [NXH_W-1:0]               o_nxh,
    output logic [EW-1:0]                  o_ny,
    output logic [EW-1:0]                  o_nz,
    output logic [EW-1:0]                  o_nt,
    output logic [SY_W-1:0]                o_sy,
    output logic [SZ_W-1:0]                o_sz,
    output logic [VOL_W-1:0]               o_vol
);

    logic [clni_pkg::XH_REG_W-1:0]  r_xh;
    logic [clni_pkg::EXT_REG_W-1:0] r_ye;
    logic [clni_pkg::EXT_REG_W-1:0] r_ze;
    logic [clni_pkg::EXT_REG_W-1:0] r_te;
    logic [SY_W-1:0]                r_sy;
    logic [SZ_W-1:0]                r_sz;
    logic [VOL_W-1:0]               r_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xh <= clni_pkg::XH_RST;
            r_ye <= clni_pkg::EXT_RST;
            r_ze <= clni_pkg::EXT_RST;
            r_te <= clni_pkg::EXT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                clni_pkg::REG_X_HALF: begin
                    r_xh <= i_cfg_wdata[clni_pkg::XH_REG_W-1:0];
                end
                clni_pkg::REG_Y_EXT: begin
                    r_ye <= i_cfg_wdata[clni_pkg::EXT_REG_W-1:0];
                end
                clni_pkg::REG_Z_EXT: begin
                    r_ze <= i_cfg_wdata[clni_pkg::EXT_REG_W-1:0];
                end
                clni_pkg::REG_T_EXT: begin
                    r_te <= i_cfg_wdata[clni_pkg::EXT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_nxh = (32'(r_xh) > 32'(MAX_EXTENT / 2)) ? NXH_W'(MAX_EXTENT / 2) : NXH_W'(r_xh);
        o_ny  = (32'(r_ye) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(r_ye);
        o_nz  = (32'(r_ze) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(r_ze);
        o_nt  = (32'(r_te) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(r_te);
    end

    // strides settle via sy, sz, vol after a write, within the pipeline latency
    always_ff @(posedge i_clk) begin
        r_sy  <= SY_W'(o_nxh) * SY_W'(o_ny);
        r_sz  <= SZ_W'(r_sy) * SZ_W'(o_nz);
        r_vol <= VOL_W'(r_sz) * VOL_W'(o_nt);
    end

    assign o_sy  = r_sy;
    assign o_sz  = r_sz;
    assign o_vol = r_vol;

endmodule

### hw/rtl/clni_nbr.sv
// Neighbor offset selection and index adders, two register stages.
module clni_nbr #(
    parameter int NXH_W = 6,
    parameter int EW    = 7,
    parameter int TW    = 6,
    parameter int SY_W  = 13,
    parameter int SZ_W  = 20,
    parameter int VOL_W = 27
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [clni_pkg::IDX_W-1:0]        i_site,
    input  logic                              i_par,
    input  logic [NXH_W-1:0]                  i_xcb,
    input  logic [EW-1:0]                     i_y,
    input  logic [EW-1:0]                     i_z,
    input  logic [TW-1:0]                     i_t,
    input  logic [NXH_W-1:0]                  i_nxh,
    input  logic [EW-1:0]                     i_ny,
    input  logic [EW-1:0]                     i_nz,
    input  logic [EW-1:0]                     i_nt,
    input  logic [SY_W-1:0]                   i_sy,
    input  logic [SZ_W-1:0]                   i_sz,
    input  logic [VOL_W-1:0]                  i_vol,
    output logic                              o_vld,
    output logic [7:0][clni_pkg::IDX_W-1:0]   o_nbr,
    output logic                              o_src_par,
    output logic                              o_oor
);

    localparam int IW    = clni_pkg::IDX_W;
    localparam int CMP_W = (VOL_W > IW) ? VOL_W : IW;
    localparam logic [IW-1:0] ZERO = IW'(0);
    localparam logic [IW-1:0] ONE  = IW'(1);

    logic                 n_p;
    logic [IW-1:0]        n_sx;
    logic [IW-1:0]        n_sy;
    logic [IW-1:0]        n_sz;
    logic [IW-1:0]        n_sv;
    logic                 n_oor;
    logic [7:0][IW-1:0]   n_dlt;
    logic [7:0][IW-1:0]   n_nbr;

    logic                 r_v1;
    logic [IW-1:0]        r_site;
    logic                 r_par1;
    logic                 r_oor1;
    logic [7:0][IW-1:0]   r_dlt;

    logic                 r_v2;
    logic [7:0][IW-1:0]   r_nbr;
    logic                 r_src_par;
    logic                 r_oor2;

    // offsets are taken mod 2^IDX_W; a wrap adds or removes one full period
    always_comb begin
        n_p   = i_par ^ i_y[0] ^ i_z[0] ^ i_t[0];
        n_sx  = IW'(i_nxh);
        n_sy  = IW'(i_sy);
        n_sz  = IW'(i_sz);
        n_sv  = IW'(i_vol);
        n_oor = (CMP_W'(i_site) >= CMP_W'(i_vol));

        n_dlt[0] = n_p ? ((i_xcb == i_nxh - NXH_W'(1)) ? ZERO - IW'(i_xcb) : ONE) : ZERO;
        n_dlt[1] = n_p ? ZERO : ((i_xcb == NXH_W'(0)) ? n_sx - ONE : ZERO - ONE);
        n_dlt[2] = (i_y == i_ny - EW'(1)) ? n_sx - n_sy : n_sx;
        n_dlt[3] = (i_y == EW'(0)) ? n_sy - n_sx : ZERO - n_sx;
        n_dlt[4] = (i_z == i_nz - EW'(1)) ? n_sy - n_sz : n_sy;
        n_dlt[5] = (i_z == EW'(0)) ? n_sz - n_sy : ZERO - n_sy;
        n_dlt[6] = (EW'(i_t) == i_nt - EW'(1)) ? n_sz - n_sv : n_sz;
        n_dlt[7] = (i_t == TW'(0)) ? n_sv - n_sz : ZERO - n_sz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
        end
        r_site <= i_site;
        r_par1 <= i_par;
        r_oor1 <= n_oor;
        r_dlt  <= n_dlt;
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_nbr[k] = r_oor1 ? ZERO : r_site + r_dlt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_nbr     <= n_nbr;
        r_src_par <= ~r_par1;
        r_oor2    <= r_oor1;
    end

    assign o_vld     = r_v2;
    assign o_nbr     = r_nbr;
    assign o_src_par = r_src_par;
    assign o_oor     = r_oor2;

endmodule

### hw/rtl/checkerboard_lattice_neighbor_index.sv
// Top level of the checkerboard lattice neighbor index generator.
// One site transfer can be taken every clock cycle while busy is low; busy is high during
// reset and in the first cycle after it. The result of a transfer shows on the o_ ports
// with o_done once it has passed the divider and neighbor stages and cannot be held off,
// so results leave in order at the input rate. Three chained divider pipelines peel x-half,
// y and z off the site index one quotient bit per stage behind a load stage (19, 13 and 7
// stages at the default), followed by two stages that pick the wrap offsets and add them.
// Extent registers may only be written while no transfer is in flight; products derived
// from them settle after a write through the registered products sy, sz and vol in turn.
module checkerboard_lattice_neighbor_index #(
    parameter int MAX_EXTENT = clni_pkg::MAX_EXTENT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [clni_pkg::IDX_W-1:0]      i_site_index,
    input  logic                            i_target_parity,
    input  logic                            i_cfg_we,
    input  logic [clni_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [clni_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                            o_done,
    output logic [clni_pkg::IDX_W-1:0]      o_x_fwd_site,
    output logic [clni_pkg::IDX_W-1:0]      o_x_back_site,
    output logic [clni_pkg::IDX_W-1:0]      o_y_fwd_site,
    output logic [clni_pkg::IDX_W-1:0]      o_y_back_site,
    output logic [clni_pkg::IDX_W-1:0]      o_z_fwd_site,
    output logic [clni_pkg::IDX_W-1:0]      o_z_back_site,
    output logic [clni_pkg::IDX_W-1:0]      o_t_fwd_site,
    output logic [clni_pkg::IDX_W-1:0]      o_t_back_site,
    output logic                            o_source_parity,
    output logic                            o_out_of_range
);

    localparam int IW    = clni_pkg::IDX_W;
    localparam int NXH_W = $clog2(MAX_EXTENT / 2 + 1);
    localparam int EW    = $clog2(MAX_EXTENT + 1);
    localparam int SY_W  = NXH_W + EW;
    localparam int SZ_W  = SY_W + EW;
    localparam int VOL_W = SZ_W + EW;
    localparam int Q1    = clni_pkg::clni_q1(MAX_EXTENT);
    localparam int Q2    = clni_pkg::clni_q2(MAX_EXTENT);
    localparam int Q3    = clni_pkg::clni_q3(MAX_EXTENT);
    localparam int P1_W  = IW + 1;
    localparam int P2_W  = P1_W + NXH_W;
    localparam int P3_W  = P2_W + EW;

    logic                r_busy;
    logic                n_acc;

    logic [NXH_W-1:0]    nxh;
    logic [EW-1:0]       ny;
    logic [EW-1:0]       nz;
    logic [EW-1:0]       nt;
    logic [SY_W-1:0]     sy;
    logic [SZ_W-1:0]     sz;
    logic [VOL_W-1:0]    vol;

    logic                d1_vld;
    logic [Q1-1:0]       d1_quo;
    logic [NXH_W-1:0]    d1_rem;
    logic [P1_W-1:0]     d1_pay;

    logic                d2_vld;
    logic [Q2-1:0]       d2_quo;
    logic [EW-1:0]       d2_rem;
    logic [P2_W-1:0]     d2_pay;

    logic                d3_vld;
    logic [Q3-1:0]       d3_quo;
    logic [EW-1:0]       d3_rem;
    logic [P3_W-1:0]     d3_pay;

    logic [7:0][IW-1:0]  nbr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy  = r_busy;
    assign n_acc = start & ~r_busy;

    clni_cfg #(
        .MAX_EXTENT (MAX_EXTENT),
        .NXH_W      (NXH_W),
        .EW         (EW),
        .SY_W       (SY_W),
        .SZ_W       (SZ_W),
        .VOL_W      (VOL_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_nxh       (nxh),
        .o_ny        (ny),
        .o_nz        (nz),
        .o_nt        (nt),
        .o_sy        (sy),
        .o_sz        (sz),
        .o_vol       (vol)
    );

    // site / Nxh -> yzt, remainder is the x-half coordinate
    clni_div #(.DW(IW), .VW(NXH_W), .QW(Q1), .PW(P1_W)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (n_acc),
        .i_dividend (i_site_index),
        .i_divisor  (nxh),
        .i_pay      ({i_site_index, i_target_parity}),
        .o_vld      (d1_vld),
        .o_quo      (d1_quo),
        .o_rem      (d1_rem),
        .o_pay      (d1_pay)
    );

    // yzt / Ny -> zt, remainder y
    clni_div #(.DW(Q1), .VW(EW), .QW(Q2), .PW(P2_W)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (d1_vld),
        .i_dividend (d1_quo),
        .i_divisor  (ny),
        .i_pay      ({d1_pay, d1_rem}),
        .o_vld      (d2_vld),
        .o_quo      (d2_quo),
        .o_rem      (d2_rem),
        .o_pay      (d2_pay)
    );

    // zt / Nz -> t, remainder z
    clni_div #(.DW(Q2), .VW(EW), .QW(Q3), .PW(P3_W)) u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (d2_vld),
        .i_dividend (d2_quo),
        .i_divisor  (nz),
        .i_pay      ({d2_pay, d2_rem}),
        .o_vld      (d3_vld),
        .o_quo      (d3_quo),
        .o_rem      (d3_rem),
        .o_pay      (d3_pay)
    );

    clni_nbr #(
        .NXH_W (NXH_W),
        .EW    (EW),
        .TW    (Q3),
        .SY_W  (SY_W),
        .SZ_W  (SZ_W),
        .VOL_W (VOL_W)
    ) u_nbr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (d3_vld),
        .i_site    (d3_pay[P3_W-1 -: IW]),
        .i_par     (d3_pay[NXH_W + EW]),
        .i_xcb     (d3_pay[EW +: NXH_W]),
        .i_y       (d3_pay[EW-1:0]),
        .i_z       (d3_rem),
        .i_t       (d3_quo),
        .i_nxh     (nxh),
        .i_ny      (ny),
        .i_nz      (nz),
        .i_nt      (nt),
        .i_sy      (sy),
        .i_sz      (sz),
        .i_vol     (vol),
        .o_vld     (o_done),
        .o_nbr     (nbr),
        .o_src_par (o_source_parity),
        .o_oor     (o_out_of_range)
    );

    assign o_x_fwd_site  = nbr[0];
    assign o_x_back_site = nbr[1];
    assign o_y_fwd_site  = nbr[2];
    assign o_y_back_site = nbr[3];
    assign o_z_fwd_site  = nbr[4];
    assign o_z_back_site = nbr[5];
    assign o_t_fwd_site  = nbr[6];
    assign o_t_back_site = nbr[7];

endmodule

### hw/rtl/clni_chk.sv
// Port-level checker for the lattice neighbor index block, bound to the top level.
module clni_chk #(
    parameter int MAX_EXTENT = clni_pkg::MAX_EXTENT_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_target_parity,
    input logic                       o_done,
    input logic [clni_pkg::IDX_W-1:0] o_x_fwd_site,
    input logic [clni_pkg::IDX_W-1:0] o_x_back_site,
    input logic [clni_pkg::IDX_W-1:0] o_y_fwd_site,
    input logic [clni_pkg::IDX_W-1:0] o_y_back_site,
    input logic [clni_pkg::IDX_W-1:0] o_z_fwd_site,
    input logic [clni_pkg::IDX_W-1:0] o_z_back_site,
    input logic [clni_pkg::IDX_W-1:0] o_t_fwd_site,
    input logic [clni_pkg::IDX_W-1:0] o_t_back_site,
    input logic                       o_source_parity,
    input logic                       o_out_of_range
);

    localparam int LAT = clni_pkg::clni_latency(MAX_EXTENT);

    logic acc;
    assign acc = start && !busy;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##LAT o_done)
        else $error("transfer without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |-> ##LAT !o_done)
        else $error("result without transfer");

    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##LAT (o_source_parity == !$past(i_target_parity, LAT)))
        else $error("source parity mismatch");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_of_range) |->
            (o_x_fwd_site == '0 && o_x_back_site == '0 && o_y_fwd_site == '0 &&
             o_y_back_site == '0 && o_z_fwd_site == '0 && o_z_back_site == '0 &&
             o_t_fwd_site == '0 && o_t_back_site == '0))
        else $error("out-of-range site with nonzero neighbors");

endmodule

bind checkerboard_lattice_neighbor_index clni_chk #(.MAX_EXTENT(MAX_EXTENT)) u_clni_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_target_parity (i_target_parity),
    .o_done          (o_done),
    .o_x_fwd_site    (o_x_fwd_site),
    .o_x_back_site   (o_x_back_site),
    .o_y_fwd_site    (o_y_fwd_site),
    .o_y_back_site   (o_y_back_site),
    .o_z_fwd_site    (o_z_fwd_site),
    .o_z_back_site   (o_z_back_site),
    .o_t_fwd_site    (o_t_fwd_site),
    .o_t_back_site   (o_t_back_site),
    .o_source_parity (o_source_parity),
    .o_out_of_range  (o_out_of_range)
);

### tb/checkerboard_lattice_neighbor_index_tb.sv
// Self-checking testbench for the checkerboard lattice neighbor index generator.
`timescale 1ns / 100ps

module checkerboard_lattice_neighbor_index_tb;

    localparam int LATENCY = clni_pkg::clni_latency(clni_pkg::MAX_EXTENT_DEF);
    localparam int MAX_EXT = clni_pkg::MAX_EXTENT_DEF;

    typedef logic [clni_pkg::IDX_W-1:0]      t_site;
    typedef logic [clni_pkg::CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [clni_pkg::CFG_DATA_W-1:0] t_cfg_data;

    // nbr[0..7]: x+, x-, y+, y-, z+, z-, t+, t-
    typedef struct packed {
        logic [7:0][clni_pkg::IDX_W-1:0] nbr;
        logic                            src_par;
        logic                            oor;
    } t_nbr_set;

    class t_neighbor_board;
        longint unsigned nxh, ny, nz, nt;
        t_nbr_set        pending_sets[$];
        string           dir_names[8];
        int              errors;

        function new();
            nxh = clni_pkg::XH_RST;
            ny = clni_pkg::EXT_RST;
            nz = clni_pkg::EXT_RST;
            nt = clni_pkg::EXT_RST;
            errors = 0;
            dir_names = '{"x_fwd_site", "x_back_site", "y_fwd_site", "y_back_site",
                          "z_fwd_site", "z_back_site", "t_fwd_site", "t_back_site"};
        endfunction

        function longint unsigned volume();
            return nxh * ny * nz * nt;
        endfunction

        // extents above the maximum saturate
        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            longint unsigned xhv;
            longint unsigned ext;
            xhv = data[clni_pkg::XH_REG_W-1:0];
            ext = data[clni_pkg::EXT_REG_W-1:0];
            case (idx)
                clni_pkg::REG_X_HALF: nxh = (xhv > MAX_EXT / 2) ? MAX_EXT / 2 : xhv;
                clni_pkg::REG_Y_EXT:  ny = (ext > MAX_EXT) ? MAX_EXT : ext;
                clni_pkg::REG_Z_EXT:  nz = (ext > MAX_EXT) ? MAX_EXT : ext;
                clni_pkg::REG_T_EXT:  nt = (ext > MAX_EXT) ? MAX_EXT : ext;
                default: ;
            endcase
        endfunction

        function t_nbr_set neighbors_of(t_site site, logic par);
            t_nbr_set        r;
            longint unsigned s, yzt, xcb, zt, y, z, t, x, nx, base;
            longint unsigned xp, xm, yp, ym, zp, zm, tp, tm;
            r = '0;
            r.src_par = ~par;
            s = site;
            if (s >= volume()) begin
                r.oor = 1'b1;
                return r;
            end
            yzt = s / nxh;
            xcb = s - nxh * yzt;
            zt = yzt / ny;
            y = yzt - ny * zt;
            t = zt / nz;
            z = zt - nz * t;
            nx = 2 * nxh;
            x = 2 * xcb + ((par + y + z + t) & 64'd1);
            xp = ((x + 1 < nx) ? x + 1 : 64'd0) / 2;
            xm = ((x > 0) ? x - 1 : nx - 1) / 2;
            yp = (y + 1 < ny) ? y + 1 : 64'd0;
            ym = (y > 0) ? y - 1 : ny - 1;
            zp = (z + 1 < nz) ? z + 1 : 64'd0;
            zm = (z > 0) ? z - 1 : nz - 1;
            tp = (t + 1 < nt) ? t + 1 : 64'd0;
            tm = (t > 0) ? t - 1 : nt - 1;
            base = nxh * (y + ny * (z + nz * t));
            r.nbr[0] = t_site'(xp + base);
            r.nbr[1] = t_site'(xm + base);
            r.nbr[2] = t_site'(xcb + nxh * (yp + ny * (z + nz * t)));
            r.nbr[3] = t_site'(xcb + nxh * (ym + ny * (z + nz * t)));
            r.nbr[4] = t_site'(xcb + nxh * (y + ny * (zp + nz * t)));
            r.nbr[5] = t_site'(xcb + nxh * (y + ny * (zm + nz * t)));
            r.nbr[6] = t_site'(xcb + nxh * (y + ny * (z + nz * tp)));
            r.nbr[7] = t_site'(xcb + nxh * (y + ny * (z + nz * tm)));
            return r;
        endfunction

        function void note_site(t_site site, logic par);
            pending_sets.push_back(neighbors_of(site, par));
        endfunction

        function int pending();
            return pending_sets.size();
        endfunction

        function void check_result(t_nbr_set got);
            t_nbr_set want;
            int       k;
            if (pending_sets.size() == 0) begin
                $error("result transfer with no site pending");
                errors++;
                return;
            end
            want = pending_sets.pop_front();
            for (k = 0; k < 8; k++) begin
                if (got.nbr[k] !== want.nbr[k]) begin
                    $error("%s: expected %0d, actual %0d", dir_names[k], want.nbr[k],
                           got.nbr[k]);
                    errors++;
                end
            end
            if (got.src_par !== want.src_par) begin
                $error("source_parity: expected %0d, actual %0d", want.src_par, got.src_par);
                errors++;
            end
            if (got.oor !== want.oor) begin
                $error("out_of_range: expected %0d, actual %0d", want.oor, got.oor);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_site                 i_site_index = '0;
    logic                  i_target_parity = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_addr = clni_pkg::REG_X_HALF;
    t_cfg_data             i_cfg_wdata = '0;
    logic                  o_done;
    t_site                 o_x_fwd_site, o_x_back_site, o_y_fwd_site, o_y_back_site;
    t_site                 o_z_fwd_site, o_z_back_site, o_t_fwd_site, o_t_back_site;
    logic                  o_source_parity;
    logic                  o_out_of_range;

    t_neighbor_board board = new();
    int              no_gap_run = 0;

    checkerboard_lattice_neighbor_index dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_site_index    (i_site_index),
        .i_target_parity (i_target_parity),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_x_fwd_site    (o_x_fwd_site),
        .o_x_back_site   (o_x_back_site),
        .o_y_fwd_site    (o_y_fwd_site),
        .o_y_back_site   (o_y_back_site),
        .o_z_fwd_site    (o_z_fwd_site),
        .o_z_back_site   (o_z_back_site),
        .o_t_fwd_site    (o_t_fwd_site),
        .o_t_back_site   (o_t_back_site),
        .o_source_parity (o_source_parity),
        .o_out_of_range  (o_out_of_range)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : watch
        t_nbr_set seen;
        if (i_rst_n) begin
            if (i_cfg_we)
                board.write_reg(i_cfg_addr, i_cfg_wdata);
            if (start && !busy)
                board.note_site(i_site_index, i_target_parity);
            if (o_done === 1'b1) begin
                seen.nbr = {o_t_back_site, o_t_fwd_site, o_z_back_site, o_z_fwd_site,
                            o_y_back_site, o_y_fwd_site, o_x_back_site, o_x_fwd_site};
                seen.src_par = o_source_parity;
                seen.oor = o_out_of_range;
                board.check_result(seen);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gap_run > 0) begin
            no_gap_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            no_gap_run = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly in-range sites, some at the volume edge, some anywhere
    function automatic t_site pick_site(longint unsigned vol);
        int r;
        r = $urandom_range(0, 99);
        if (vol == 0)
            return t_site'($urandom());
        if (r < 80)
            return t_site'($urandom_range(0, 32'(vol - 1)));
        if (r < 86)
            return r[0] ? t_site'(vol - 1) : '0;
        if (r < 92 && vol < (64'd1 << clni_pkg::IDX_W))
            return t_site'(vol);
        return t_site'($urandom());
    endfunction

    function automatic t_cfg_data pick_extent(int common_hi, int sat_lo);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 12)
            return t_cfg_data'($urandom_range(sat_lo, 127));
        return t_cfg_data'($urandom_range(1, common_hi));
    endfunction

    task automatic send_site(t_site site, logic par);
        int gap;
        start <= 1'b1;
        i_site_index <= site;
        i_target_parity <= par;
        do @(posedge i_clk); while (busy);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic write_extents(t_cfg_data xh, t_cfg_data y, t_cfg_data z, t_cfg_data t);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= clni_pkg::REG_X_HALF;
        i_cfg_wdata <= xh;
        @(posedge i_clk);
        i_cfg_addr <= clni_pkg::REG_Y_EXT;
        i_cfg_wdata <= y;
        @(posedge i_clk);
        i_cfg_addr <= clni_pkg::REG_Z_EXT;
        i_cfg_wdata <= z;
        @(posedge i_clk);
        i_cfg_addr <= clni_pkg::REG_T_EXT;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // let derived products settle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(t_cfg_data xh, t_cfg_data y, t_cfg_data z, t_cfg_data t,
                             int n, bit hold_mid);
        int k;
        drain();
        write_extents(xh, y, z, t);
        for (k = 0; k < n; k++) begin
            if (hold_mid && k == n / 2) begin
                start <= 1'b0;
                drain();
            end
            send_site(pick_site(board.volume()), 1'($urandom()));
        end
        start <= 1'b0;
    endtask

    initial begin
        t_site dir_sites [11] = '{23'd0, 23'd1, 23'd3, 23'd4, 23'd28, 23'd1024, 23'd2044,
                                  23'd2047, 23'd2048, 23'h2AAAAA, 23'h7FFFFF};
        int    k;
        int    p;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset extents: corners, volume edge, beyond volume
        for (k = 0; k < 11; k++)
            for (p = 0; p < 2; p++)
                send_site(dir_sites[k], 1'(p));
        start <= 1'b0;

        run_phase(7'd1, 7'd1, 7'd1, 7'd1, 100, 1'b0);
        run_phase(7'd32, 7'd64, 7'd64, 7'd64, 300, 1'b1);
        run_phase(7'd127, 7'd127, 7'd127, 7'd127, 150, 1'b0);
        run_phase(7'd0, 7'd8, 7'd8, 7'd8, 60, 1'b0);
        run_phase(7'd5, 7'd3, 7'd1, 7'd7, 100, 1'b0);
        run_phase(7'd2, 7'd2, 7'd2, 7'd2, 150, 1'b0);
        for (k = 0; k < 9; k++)
            run_phase(pick_extent(8, 33), pick_extent(10, 65), pick_extent(10, 65),
                      pick_extent(10, 65), 100, 1'b0);

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
